>>> rtl/core/cvme_pkg.sv
// cvme_pkg: shared types, command codes and helper functions of the camera view matrix engine
// no dependencies; imported by camera_view_matrix_engine
package cvme_pkg;

   typedef logic [2:0]         func_type;
   typedef logic [1:0]         vsel_type;
   typedef logic signed [31:0] comp_type;

   localparam func_type FUNC_LOAD    = 3'd0;
   localparam func_type FUNC_FORWARD = 3'd1;
   localparam func_type FUNC_BACK    = 3'd2;
   localparam func_type FUNC_LEFT    = 3'd3;
   localparam func_type FUNC_RIGHT   = 3'd4;
   localparam func_type FUNC_UP      = 3'd5;
   localparam func_type FUNC_DOWN    = 3'd6;
   localparam func_type FUNC_REFRESH = 3'd7;

   localparam vsel_type SEL_UP    = 2'd0;
   localparam vsel_type SEL_LOOK  = 2'd1;
   localparam vsel_type SEL_RIGHT = 2'd2;
   localparam vsel_type SEL_POS   = 2'd3;

   localparam logic signed [64:0] SAT_MAX = 65'sh0_7fff_ffff;
   localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

   function automatic comp_type sat32(input logic signed [64:0] v);
      if (v > SAT_MAX) begin
         return comp_type'(SAT_MAX[31:0]);
      end else if (v < SAT_MIN) begin
         return comp_type'(SAT_MIN[31:0]);
      end
      return v[31:0];
   endfunction

   // cyclic component order for cross products
   function automatic logic [1:0] idx_next(input logic [1:0] k);
      return (k == 2'd2) ? 2'd0 : k + 2'd1;
   endfunction

   function automatic logic [1:0] idx_prev(input logic [1:0] k);
      return (k == 2'd0) ? 2'd2 : k - 2'd1;
   endfunction

endpackage

>>> rtl/core/camera_view_matrix_engine.sv
// camera_view_matrix_engine: camera basis and position store, move and re-orthonormalize
// sequencer around one shared 32x32 multiplier, square root and restoring divider
// depends on cvme_pkg
//
// usage:
//   req channel (valid/ready) takes one command per transfer. a load writes one
//   vector (up, look, right or position) and gives no result.
//   move and refresh commands rebuild the basis and return four rsp transfers,
//   matrix rows 0 to 3 in order, last_row set on row 3.
//   csr channel writes move_step; csr_ready is always high, write only when idle.
// work: the time of a move or refresh is set by the shared multiplier (move, squares,
//   cross and dot products), the 32-step square root and FRAC_BITS+1 divider steps per
//   component over three normalizations, plus up to 32 one-bit shifts per cross product
//   to bring it in range. a zero vector skips root and divide, which shortens the work
//   on an all-zero basis.
// throughput: one command at a time; req_ready is low until the last row transfers.
// reset: synchronous, clears the stored vectors (up, look, right, position) to zero and move_step to one.
// a stalled receiver holds the current row in the output register; the block
//   waits without losing or repeating rows.
module camera_view_matrix_engine #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cvme_pkg::func_type req_func,
   input  cvme_pkg::vsel_type req_vector_select,
   input  cvme_pkg::comp_type req_comp_x,
   input  cvme_pkg::comp_type req_comp_y,
   input  cvme_pkg::comp_type req_comp_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output cvme_pkg::comp_type rsp_col0,
   output cvme_pkg::comp_type rsp_col1,
   output cvme_pkg::comp_type rsp_col2,
   output cvme_pkg::comp_type rsp_col3,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  cvme_pkg::comp_type csr_wdata
);
   import cvme_pkg::*;

   localparam int QW    = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam comp_type ONE_VAL = comp_type'(32'd1 << FRAC_BITS);

   typedef enum logic [4:0] {
      S_IDLE, S_MOVE_MUL, S_MOVE_ADD, S_FIT, S_SQ_MUL, S_SQ_ACC, S_SQRT,
      S_DIV_INIT, S_DIV, S_NORM_NEXT, S_CROSS_MUL, S_CROSS_ACC,
      S_DOT_MUL, S_DOT_ACC, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] row_ff, row_in;
   logic       term_ff, term_in;
   logic       cross_sel_ff, cross_sel_in;
   vsel_type   target_ff, target_in;
   comp_type   step_ff, step_in;
   comp_type   up_ff [3], up_in [3];
   comp_type   look_ff [3], look_in [3];
   comp_type   right_ff [3], right_in [3];
   comp_type   pos_ff [3], pos_in [3];
   comp_type   dot_ff [3], dot_in [3];
   logic signed [63:0] vec_ff [3], vec_in [3];
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [32:0] len_ff, len_in;
   logic [32:0] rem_ff, rem_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic       lsb_ff, lsb_in;
   logic       neg_ff, neg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;
   comp_type   rsp_col0_ff, rsp_col0_in;
   comp_type   rsp_col1_ff, rsp_col1_in;
   comp_type   rsp_col2_ff, rsp_col2_in;
   comp_type   rsp_col3_ff, rsp_col3_in;

   // datapath helpers
   comp_type   mul_a, mul_b;
   comp_type   move_dir [3];
   comp_type   cross_a [3], cross_b [3];
   comp_type   dot_dir [3];
   logic       move_sub;
   logic signed [63:0] move_d;
   logic signed [64:0] move_sum;
   logic [63:0] sq_sum;
   logic [64:0] sq_trial;
   logic       sq_ge;
   logic [31:0] div_mag;
   logic       div_bit;
   logic [33:0] div_trial, div_rem;
   logic       div_ge;
   logic [QW-1:0] quot_next;
   comp_type   div_val;
   logic signed [63:0] dot_s, dot_t;
   logic signed [64:0] dot_v;
   logic       fits_all;
   logic [1:0] pay_row;
   comp_type   pay_c0, pay_c1, pay_c2, pay_c3;

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_col0      = rsp_col0_ff;
   assign rsp_col1      = rsp_col1_ff;
   assign rsp_col2      = rsp_col2_ff;
   assign rsp_col3      = rsp_col3_ff;
   assign rsp_last_row  = rsp_last_ff;

   always_comb begin
      case (func_ff)
         FUNC_FORWARD, FUNC_BACK: move_dir = look_ff;
         FUNC_LEFT, FUNC_RIGHT:   move_dir = right_ff;
         default:                 move_dir = up_ff;
      endcase
      move_sub = (func_ff == FUNC_BACK) || (func_ff == FUNC_LEFT) || (func_ff == FUNC_DOWN);
      cross_a  = cross_sel_ff ? up_ff : look_ff;
      cross_b  = cross_sel_ff ? right_ff : up_ff;
      case (row_ff)
         2'd0:    dot_dir = right_ff;
         2'd1:    dot_dir = up_ff;
         default: dot_dir = look_ff;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MOVE_MUL: begin
            mul_a = step_ff;
            mul_b = move_dir[idx_ff];
         end
         S_SQ_MUL: begin
            mul_a = vec_ff[idx_ff][31:0];
            mul_b = vec_ff[idx_ff][31:0];
         end
         S_CROSS_MUL: begin
            if (!term_ff) begin
               mul_a = cross_a[idx_next(idx_ff)];
               mul_b = cross_b[idx_prev(idx_ff)];
            end else begin
               mul_a = cross_a[idx_prev(idx_ff)];
               mul_b = cross_b[idx_next(idx_ff)];
            end
         end
         S_DOT_MUL: begin
            mul_a = pos_ff[idx_ff];
            mul_b = dot_dir[idx_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // vector is in 32-bit range when its top 33 bits are all equal
   always_comb begin
      fits_all = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!((&vec_ff[i][63:31]) || !(|vec_ff[i][63:31]))) begin
            fits_all = 1'b0;
         end
      end
   end

   assign move_d   = prod_ff >>> FRAC_BITS;
   assign move_sum = move_sub ? (65'(pos_ff[idx_ff]) - 65'(move_d))
                              : (65'(pos_ff[idx_ff]) + 65'(move_d));
   assign sq_sum   = acc_ff + $unsigned(prod_ff);
   assign sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign sq_ge    = ({1'b0, acc_ff} >= sq_trial);
   assign div_mag  = vec_ff[idx_ff][31] ? (32'd0 - vec_ff[idx_ff][31:0]) : vec_ff[idx_ff][31:0];
   // first divider step brings in the low magnitude bit, later steps bring zeros
   assign div_bit   = (div_cnt_ff == CNT_W'(FRAC_BITS)) ? lsb_ff : 1'b0;
   assign div_trial = {rem_ff, div_bit};
   assign div_ge    = (div_trial >= {1'b0, len_ff});
   assign div_rem   = div_ge ? (div_trial - {1'b0, len_ff}) : div_trial;
   assign quot_next = {quot_ff[QW-2:0], div_ge};
   assign div_val   = neg_ff ? (32'd0 - 32'(quot_next)) : 32'(quot_next);
   assign dot_s     = $signed(acc_ff) + prod_ff;
   assign dot_t     = dot_s >>> FRAC_BITS;
   assign dot_v     = (row_ff == 2'd2) ? 65'(dot_t) : -65'(dot_t);

   // payload of the row that goes into the output register next
   assign pay_row = (state_ff == S_EMIT) ? row_ff + 2'd1 : 2'd0;
   always_comb begin
      if (pay_row == 2'd3) begin
         pay_c0 = dot_ff[0];
         pay_c1 = dot_ff[1];
         pay_c2 = dot_ff[2];
         pay_c3 = ONE_VAL;
      end else begin
         pay_c0 = right_ff[pay_row];
         pay_c1 = up_ff[pay_row];
         pay_c2 = look_ff[pay_row];
         pay_c3 = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      term_in      = term_ff;
      cross_sel_in = cross_sel_ff;
      target_in    = target_ff;
      step_in      = step_ff;
      up_in        = up_ff;
      look_in      = look_ff;
      right_in     = right_ff;
      pos_in       = pos_ff;
      dot_in       = dot_ff;
      vec_in       = vec_ff;
      prod_in      = 64'(mul_a) * 64'(mul_b);
      acc_in       = acc_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      div_cnt_in   = div_cnt_ff;
      lsb_in       = lsb_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_col0_in  = rsp_col0_ff;
      rsp_col1_in  = rsp_col1_ff;
      rsp_col2_in  = rsp_col2_ff;
      rsp_col3_in  = rsp_col3_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in = 2'd0;
               if (req_func == FUNC_LOAD) begin
                  case (req_vector_select)
                     SEL_UP:    up_in    = '{req_comp_x, req_comp_y, req_comp_z};
                     SEL_LOOK:  look_in  = '{req_comp_x, req_comp_y, req_comp_z};
                     SEL_RIGHT: right_in = '{req_comp_x, req_comp_y, req_comp_z};
                     default:   pos_in   = '{req_comp_x, req_comp_y, req_comp_z};
                  endcase
               end else begin
                  func_in = req_func;
                  if (req_func == FUNC_REFRESH) begin
                     for (int i = 0; i < 3; i++) vec_in[i] = 64'(up_ff[i]);
                     target_in = SEL_UP;
                     state_in  = S_FIT;
                  end else begin
                     state_in = S_MOVE_MUL;
                  end
               end
            end
         end
         S_MOVE_MUL: state_in = S_MOVE_ADD;
         S_MOVE_ADD: begin
            pos_in[idx_ff] = sat32(move_sum);
            if (idx_ff == 2'd2) begin
               for (int i = 0; i < 3; i++) vec_in[i] = 64'(up_ff[i]);
               target_in = SEL_UP;
               idx_in    = 2'd0;
               state_in  = S_FIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_MOVE_MUL;
            end
         end
         S_FIT: begin
            if (fits_all) begin
               idx_in   = 2'd0;
               acc_in   = '0;
               state_in = S_SQ_MUL;
            end else begin
               for (int i = 0; i < 3; i++) vec_in[i] = vec_ff[i] >>> 1;
            end
         end
         S_SQ_MUL: state_in = S_SQ_ACC;
         S_SQ_ACC: begin
            acc_in = sq_sum;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               if (sq_sum == 64'd0) begin
                  // zero vector normalizes to zero
                  case (target_ff)
                     SEL_UP:    up_in    = '{default: '0};
                     SEL_RIGHT: right_in = '{default: '0};
                     default:   look_in  = '{default: '0};
                  endcase
                  state_in = S_NORM_NEXT;
               end else begin
                  res_in   = '0;
                  bit_in   = 64'h4000_0000_0000_0000;
                  state_in = S_SQRT;
               end
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_SQRT: begin
            if (sq_ge) begin
               acc_in = acc_ff - sq_trial[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               len_in   = res_in[32:0];
               idx_in   = 2'd0;
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            neg_in     = vec_ff[idx_ff][31];
            rem_in     = {2'b00, div_mag[31:1]};
            lsb_in     = div_mag[0];
            quot_in    = '0;
            div_cnt_in = CNT_W'(FRAC_BITS);
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in  = div_rem[32:0];
            quot_in = quot_next;
            if (div_cnt_ff == '0) begin
               case (target_ff)
                  SEL_UP:    up_in[idx_ff]    = div_val;
                  SEL_RIGHT: right_in[idx_ff] = div_val;
                  default:   look_in[idx_ff]  = div_val;
               endcase
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = S_NORM_NEXT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_DIV_INIT;
               end
            end else begin
               div_cnt_in = div_cnt_ff - CNT_W'(1);
            end
         end
         S_NORM_NEXT: begin
            idx_in  = 2'd0;
            term_in = 1'b0;
            case (target_ff)
               SEL_UP: begin
                  cross_sel_in = 1'b0;
                  target_in    = SEL_RIGHT;
                  state_in     = S_CROSS_MUL;
               end
               SEL_RIGHT: begin
                  cross_sel_in = 1'b1;
                  target_in    = SEL_LOOK;
                  state_in     = S_CROSS_MUL;
               end
               default: begin
                  acc_in   = '0;
                  row_in   = 2'd0;
                  state_in = S_DOT_MUL;
               end
            endcase
         end
         S_CROSS_MUL: state_in = S_CROSS_ACC;
         S_CROSS_ACC: begin
            if (!term_ff) begin
               acc_in   = $unsigned(prod_ff);
               term_in  = 1'b1;
               state_in = S_CROSS_MUL;
            end else begin
               vec_in[idx_ff] = $signed(acc_ff) - prod_ff;
               term_in        = 1'b0;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = S_FIT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_CROSS_MUL;
               end
            end
         end
         S_DOT_MUL: state_in = S_DOT_ACC;
         S_DOT_ACC: begin
            if (idx_ff == 2'd2) begin
               dot_in[row_ff] = sat32(dot_v);
               acc_in         = '0;
               idx_in         = 2'd0;
               if (row_ff == 2'd2) begin
                  row_in       = 2'd0;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b0;
                  rsp_col0_in  = pay_c0;
                  rsp_col1_in  = pay_c1;
                  rsp_col2_in  = pay_c2;
                  rsp_col3_in  = pay_c3;
                  state_in     = S_EMIT;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = S_DOT_MUL;
               end
            end else begin
               acc_in   = $unsigned(dot_s);
               idx_in   = idx_ff + 2'd1;
               state_in = S_DOT_MUL;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (row_ff == 2'd3) begin
                  rsp_valid_in = 1'b0;
                  rsp_last_in  = 1'b0;
                  row_in       = 2'd0;
                  state_in     = S_IDLE;
               end else begin
                  row_in      = pay_row;
                  rsp_last_in = (pay_row == 2'd3);
                  rsp_col0_in = pay_c0;
                  rsp_col1_in = pay_c1;
                  rsp_col2_in = pay_c2;
                  rsp_col3_in = pay_c3;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid) begin
         step_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         row_ff       <= 2'd0;
         idx_ff       <= 2'd0;
         term_ff      <= 1'b0;
         step_ff      <= ONE_VAL;
         up_ff        <= '{default: '0};
         look_ff      <= '{default: '0};
         right_ff     <= '{default: '0};
         pos_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         row_ff       <= row_in;
         idx_ff       <= idx_in;
         term_ff      <= term_in;
         step_ff      <= step_in;
         up_ff        <= up_in;
         look_ff      <= look_in;
         right_ff     <= right_in;
         pos_ff       <= pos_in;
      end
      func_ff      <= func_in;
      cross_sel_ff <= cross_sel_in;
      target_ff    <= target_in;
      dot_ff       <= dot_in;
      vec_ff       <= vec_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      div_cnt_ff   <= div_cnt_in;
      lsb_ff       <= lsb_in;
      neg_ff       <= neg_in;
      rsp_col0_ff  <= rsp_col0_in;
      rsp_col1_ff  <= rsp_col1_in;
      rsp_col2_ff  <= rsp_col2_in;
      rsp_col3_ff  <= rsp_col3_in;
   end

   a_rsp_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EMIT))
      else $error("row shown outside emit");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (row_ff == 2'd3)))
      else $error("last_row does not match row index");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < len_ff))
      else $error("divider remainder not below length");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && rsp_last_ff) |=> (state_ff == S_IDLE))
      else $error("no return to idle after last row");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && (state_ff == S_IDLE) && (req_func != FUNC_LOAD)) |=>
      (state_ff != S_IDLE))
      else $error("move or refresh did not start");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for camera_view_matrix_engine, driving commands, move steps
// and result stalls and checking every matrix row against an internal camera model
// depends on cvme_pkg and camera_view_matrix_engine
`timescale 1ns / 1ps

class row_scoreboard;
   typedef struct {
      logic [1:0]      row;
      logic [31:0]     c0, c1, c2, c3;
      logic            last;
   } row_t;

   row_t pending_rows[$];
   longint step_dist;
   longint up_v[3], look_v[3], right_v[3], pos_v[3];
   int mismatches;

   function new();
      step_dist = 64'sd65536;
      for (int i = 0; i < 3; i++) begin
         up_v[i] = 0; look_v[i] = 0; right_v[i] = 0; pos_v[i] = 0;
      end
      mismatches = 0;
   endfunction

   function void set_step(logic signed [31:0] v);
      step_dist = longint'(v);
   endfunction

   // >>> on longint floors toward minus infinity
   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function void unit_vec(input longint a[3], output longint o[3]);
      longint c[3];
      longint unsigned sum, len, mag;
      c = a;
      while (c[0] > 64'sd2147483647 || c[0] < -64'sd2147483648 ||
             c[1] > 64'sd2147483647 || c[1] < -64'sd2147483648 ||
             c[2] > 64'sd2147483647 || c[2] < -64'sd2147483648)
         for (int i = 0; i < 3; i++) c[i] = c[i] >>> 1;
      sum = 0;
      for (int i = 0; i < 3; i++) sum = sum + longint'(c[i] * c[i]);
      if (sum == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
         mag = (c[i] < 0) ? -c[i] : c[i];
         mag = (mag << 16) / len;
         o[i] = (c[i] < 0) ? -longint'(mag) : longint'(mag);
      end
   endfunction

   function void cross3(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function longint dot_q(longint a[3], longint b[3]);
      return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16;
   endfunction

   function void note_command(cvme_pkg::func_type f, cvme_pkg::vsel_type s,
                              logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
      longint v[3], d, t[3];
      row_t r;
      logic sub;
      v[0] = longint'(x); v[1] = longint'(y); v[2] = longint'(z);
      if (f == cvme_pkg::FUNC_LOAD) begin
         case (s)
            cvme_pkg::SEL_UP:    up_v = v;
            cvme_pkg::SEL_LOOK:  look_v = v;
            cvme_pkg::SEL_RIGHT: right_v = v;
            default:             pos_v = v;
         endcase
         return;
      end
      if (f != cvme_pkg::FUNC_REFRESH) begin
         sub = (f == cvme_pkg::FUNC_BACK || f == cvme_pkg::FUNC_LEFT ||
                f == cvme_pkg::FUNC_DOWN);
         for (int i = 0; i < 3; i++) begin
            if (f == cvme_pkg::FUNC_FORWARD || f == cvme_pkg::FUNC_BACK)
               d = (step_dist * look_v[i]) >>> 16;
            else if (f == cvme_pkg::FUNC_LEFT || f == cvme_pkg::FUNC_RIGHT)
               d = (step_dist * right_v[i]) >>> 16;
            else
               d = (step_dist * up_v[i]) >>> 16;
            pos_v[i] = clamp32(sub ? pos_v[i] - d : pos_v[i] + d);
         end
      end
      unit_vec(up_v, t);
      up_v = t;
      cross3(look_v, up_v, t);
      unit_vec(t, right_v);
      cross3(up_v, right_v, t);
      unit_vec(t, look_v);
      for (int i = 0; i < 3; i++) begin
         r.row = 2'(i); r.c0 = 32'(right_v[i]); r.c1 = 32'(up_v[i]);
         r.c2 = 32'(look_v[i]);
         r.c3 = '0; r.last = 1'b0;
         pending_rows.push_back(r);
      end
      r.row = 2'd3;
      r.c0 = 32'(clamp32(-dot_q(pos_v, right_v)));
      r.c1 = 32'(clamp32(-dot_q(pos_v, up_v)));
      r.c2 = 32'(clamp32(dot_q(pos_v, look_v)));
      r.c3 = 32'h0001_0000;
      r.last = 1'b1;
      pending_rows.push_back(r);
   endfunction

   function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("row mismatch on %s: got %h want %h", what, got, want);
      mismatches++;
   endfunction

   function void check_row(logic [1:0] row, logic [31:0] c0, logic [31:0] c1,
                           logic [31:0] c2, logic [31:0] c3, logic last);
      row_t w;
      if (pending_rows.size() == 0) begin
         $display("unexpected row transfer, row %0d", row);
         mismatches++;
         return;
      end
      w = pending_rows.pop_front();
      if (row !== w.row) report_mismatch("row_index", 32'(row), 32'(w.row));
      if (c0 !== w.c0) report_mismatch("col0", c0, w.c0);
      if (c1 !== w.c1) report_mismatch("col1", c1, w.c1);
      if (c2 !== w.c2) report_mismatch("col2", c2, w.c2);
      if (c3 !== w.c3) report_mismatch("col3", c3, w.c3);
      if (last !== w.last) report_mismatch("last_row", 32'(last), 32'(w.last));
   endfunction
endclass

module tb_top;
   import cvme_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   func_type req_func = FUNC_LOAD;
   vsel_type req_vector_select = SEL_UP;
   comp_type req_comp_x = 0, req_comp_y = 0, req_comp_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_row_index;
   comp_type rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic rsp_last_row;
   logic csr_valid = 0;
   logic csr_ready;
   comp_type csr_wdata = 0;

   row_scoreboard camera_sb = new();
   int idle_cycles = 0;
   int stall_mode = 0;
   int burst_left = 0;

   camera_view_matrix_engine DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            camera_sb.note_command(req_func, req_vector_select, req_comp_x,
                                   req_comp_y, req_comp_z);
         if (rsp_valid && rsp_ready)
            camera_sb.check_row(rsp_row_index, rsp_col0, rsp_col1, rsp_col2,
                                rsp_col3, rsp_last_row);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver stall pattern: periods of always ready, random and mostly stalled
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic comp_type rand_comp();
      case ($urandom_range(0, 5))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return comp_type'($urandom);
         default: return comp_type'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      endcase
   endfunction

   // valid stays up after a transfer until the next command or a drain replaces it
   task automatic send_command(func_type f, vsel_type s, comp_type x, comp_type y,
                               comp_type z);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= f;
      req_vector_select <= s;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_rows();
      req_valid <= 1'b0;
      while (camera_sb.pending_rows.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_step(comp_type v);
      drain_rows();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      camera_sb.set_step(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_basis();
      send_command(FUNC_LOAD, SEL_UP, rand_comp(), rand_comp(), rand_comp());
      send_command(FUNC_LOAD, SEL_LOOK, rand_comp(), rand_comp(), rand_comp());
      if ($urandom_range(0, 3) == 0)
         send_command(FUNC_LOAD, SEL_RIGHT, rand_comp(), rand_comp(), rand_comp());
      if ($urandom_range(0, 1) == 0)
         send_command(FUNC_LOAD, SEL_POS, rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      func_type f;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero basis, unit basis, every move, extremes
      send_command(FUNC_REFRESH, SEL_UP, 0, 0, 0);
      send_command(FUNC_LOAD, SEL_UP, 0, 32'sh0001_0000, 0);
      send_command(FUNC_LOAD, SEL_LOOK, 0, 0, -32'sh0001_0000);
      send_command(FUNC_LOAD, SEL_RIGHT, 32'sh0001_0000, 0, 0);
      send_command(FUNC_LOAD, SEL_POS, 32'sh0003_0000, -32'sh0002_0000, 32'sh0005_0000);
      for (int i = 1; i <= 7; i++) send_command(func_type'(i), SEL_UP, 0, 0, 0);
      send_command(FUNC_LOAD, SEL_POS, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      send_command(FUNC_FORWARD, SEL_POS, 0, 0, 0);
      send_command(FUNC_BACK, SEL_POS, 0, 0, 0);
      send_command(FUNC_LOAD, SEL_UP, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_command(FUNC_LOAD, SEL_LOOK, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      send_command(FUNC_REFRESH, SEL_LOOK, 0, 0, 0);
      write_step(32'sh7fff_ffff);
      send_command(FUNC_UP, SEL_UP, 0, 0, 0);
      write_step(32'sh8000_0000);
      send_command(FUNC_DOWN, SEL_UP, 0, 0, 0);
      send_command(FUNC_RIGHT, SEL_UP, 0, 0, 0);

      // random: mostly moves or refreshes, sometimes after loading a basis, with some noise commands
      for (int n = 0; n < 125; n++) begin
         if (n % 40 == 39) begin
            case ($urandom_range(0, 3))
               0: write_step(32'sh0001_0000);
               1: write_step(32'sh7fff_ffff);
               2: write_step(32'sh8000_0000);
               default: write_step(comp_type'($urandom));
            endcase
         end
         if (n == 100) drain_rows();
         if ($urandom_range(0, 4) == 0) load_basis();
         if ($urandom_range(0, 9) == 0) begin
            send_command(FUNC_LOAD, vsel_type'($urandom_range(0, 3)),
                         comp_type'($urandom), comp_type'($urandom), comp_type'($urandom));
         end else begin
            f = func_type'($urandom_range(1, 7));
            send_command(f, vsel_type'($urandom_range(0, 3)), comp_type'($urandom),
                         comp_type'($urandom), comp_type'($urandom));
         end
      end

      drain_rows();
      repeat (400) @(negedge clock);
      if (camera_sb.mismatches == 0 && camera_sb.pending_rows.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
